[design/bbp_pkg.sv]
// Shared types and constants for the bicubic Bezier patch evaluator.
// No dependencies; every other design file imports this package.
package bbp_pkg;

	// Coordinate format and control grid geometry
	localparam int COORD_W     = 16;
	localparam int NUM_C       = 3;
	localparam int GRID        = 4;
	localparam int GRID_W      = 2;
	localparam int NUM_PTS     = GRID * GRID;
	localparam int IDX_W       = 2 * GRID_W;
	localparam int NUM_W       = 4;
	localparam int PFB_DEFAULT = 16;

	// Item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	// One control or surface point, index 0 = x, 1 = y, 2 = z
	typedef logic [NUM_C-1:0][COORD_W-1:0] point_t;

	// Control point carried down the pipe by a load word
	typedef struct packed {
		logic [GRID_W-1:0] row;
		logic [GRID_W-1:0] col;
		point_t            pt;
	} load_t;

	// Write port of the control point store
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		point_t           pt;
	} cp_wr_t;

	// Load enables of the pipeline registers, one per stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} stage_en_t;

endpackage

[design/bbp_if.sv]
// Valid/ready channels of the bicubic Bezier patch evaluator.
// Depends on bbp_pkg for the coordinate width.
interface bbp_in_if #(parameter int FRAC_BITS = bbp_pkg::PFB_DEFAULT) ();
	import bbp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [GRID_W-1:0]         point_row;
	logic [GRID_W-1:0]         point_col;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic [FRAC_BITS:0]        u_param;
	logic [FRAC_BITS:0]        v_param;

	modport source(output valid, mode, point_row, point_col, coord_x, coord_y, coord_z,
		u_param, v_param, input ready);
	modport sink(input valid, mode, point_row, point_col, coord_x, coord_y, coord_z,
		u_param, v_param, output ready);
endinterface

interface bbp_out_if ();
	import bbp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] surf_x;
	logic signed [COORD_W-1:0] surf_y;
	logic signed [COORD_W-1:0] surf_z;

	modport source(output valid, surf_x, surf_y, surf_z, input ready);
	modport sink(input valid, surf_x, surf_y, surf_z, output ready);
endinterface

[design/bicubic_bezier_patch_eval.sv]
// Bicubic Bezier patch evaluator. Takes one word per cycle on item while result is not
// stalled, and gives one surface point on result for every evaluate word, in order.
// A load word writes one of the sixteen control points (row * 4 + col) and gives no
// result; the write lands as the load leaves stage 4, so any evaluate accepted after it,
// even in the next cycle, sees the new point. Eight register stages: clamp, square terms,
// cubic weights, blend weights, coordinate products, two adder levels, then rounding and
// saturation into the output register. Each stage advances when it is empty or its
// successor advances, so a stall at result holds words in place and bubbles fill up.
// Reset clears all control points to zero at once; u and v above one are clamped to one.
module bicubic_bezier_patch_eval #(
	parameter int PARAM_FRAC_BITS = bbp_pkg::PFB_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	bbp_in_if.sink    item,
	bbp_out_if.source result
);
	import bbp_pkg::*;

	localparam int P   = PARAM_FRAC_BITS;
	localparam int PRW = COORD_W + P + 2;
	localparam logic [P:0] ONE = {1'b1, {P{1'b0}}};

	stage_en_t                 en;
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic                      m_s1, m_s2, m_s3, m_s4;
	load_t                     ld_s1, ld_s2, ld_s3, ld_s4;
	logic [P:0]                tu, tv;
	logic [P:0]                au_s1, bu_s1, av_s1, bv_s1;
	logic [NUM_W-1:0][P:0]     wu_s3, wv_s3;
	cp_wr_t                    wr;
	logic signed [PRW-1:0]     prod_s5 [NUM_C][NUM_PTS];
	point_t                    surf_s8;

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		en.s8 = !v_s8 || result.ready;
		en.s7 = !v_s7 || en.s8;
		en.s6 = !v_s6 || en.s7;
		en.s5 = !v_s5 || en.s6;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign item.ready = en.s1;

	// Move valid bits; load words drop out after stage 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= item.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4 && (m_s4 == MODE_EVAL);
			if (en.s6) v_s6 <= v_s5;
			if (en.s7) v_s7 <= v_s6;
			if (en.s8) v_s8 <= v_s7;
		end
	end

	// Clamp parameters to one
	assign tu = (item.u_param > ONE) ? ONE : item.u_param;
	assign tv = (item.v_param > ONE) ? ONE : item.v_param;

	// Stage 1 capture and load payload delay line
	always_ff @(posedge clk) begin
		if (en.s1) begin
			m_s1        <= item.mode;
			ld_s1.row   <= item.point_row;
			ld_s1.col   <= item.point_col;
			ld_s1.pt[0] <= item.coord_x;
			ld_s1.pt[1] <= item.coord_y;
			ld_s1.pt[2] <= item.coord_z;
			au_s1       <= tu;
			bu_s1       <= ONE - tu;
			av_s1       <= tv;
			bv_s1       <= ONE - tv;
		end
		if (en.s2) begin
			m_s2  <= m_s1;
			ld_s2 <= ld_s1;
		end
		if (en.s3) begin
			m_s3  <= m_s2;
			ld_s3 <= ld_s2;
		end
		if (en.s4) begin
			m_s4  <= m_s3;
			ld_s4 <= ld_s3;
		end
	end

	// Write the store as a load word leaves stage 4
	assign wr.en  = v_s4 && (m_s4 == MODE_LOAD) && en.s5;
	assign wr.idx = {ld_s4.row, ld_s4.col};
	assign wr.pt  = ld_s4.pt;

	bbp_weight #(.PARAM_FRAC_BITS(P)) u_weight_u (
		.clk  (clk),
		.en   (en),
		.a_s1 (au_s1),
		.b_s1 (bu_s1),
		.w_s3 (wu_s3)
	);

	bbp_weight #(.PARAM_FRAC_BITS(P)) u_weight_v (
		.clk  (clk),
		.en   (en),
		.a_s1 (av_s1),
		.b_s1 (bv_s1),
		.w_s3 (wv_s3)
	);

	bbp_blend #(.PARAM_FRAC_BITS(P), .PRW(PRW)) u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.wu_s3   (wu_s3),
		.wv_s3   (wv_s3),
		.wr      (wr),
		.prod_s5 (prod_s5)
	);

	bbp_accum #(.PARAM_FRAC_BITS(P), .PRW(PRW)) u_accum (
		.clk     (clk),
		.en      (en),
		.prod_s5 (prod_s5),
		.surf_s8 (surf_s8)
	);

	assign result.valid  = v_s8;
	assign result.surf_x = surf_s8[0];
	assign result.surf_y = surf_s8[1];
	assign result.surf_z = surf_s8[2];

`ifndef SYNTHESIS
	a_flow_through: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> item.ready)
		else $error("input stalled while the result side takes words");

	a_load_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && (m_s4 == MODE_LOAD) && en.s5) |=> !v_s5)
		else $error("load word passed into the product stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en.s5) |=> (v_s4 && $stable(m_s4) && $stable(ld_s4)))
		else $error("stalled stage 4 word changed");
`endif

endmodule

[design/bbp_weight.sv]
// Cubic Bernstein weights of one surface parameter, two pipeline stages.
// Depends on bbp_pkg; takes t and 1 - t from stage 1, gives weights at stage 3.
module bbp_weight #(
	parameter int PARAM_FRAC_BITS = bbp_pkg::PFB_DEFAULT
) (
	input  logic                                      clk,
	input  bbp_pkg::stage_en_t                        en,
	input  logic [PARAM_FRAC_BITS:0]                  a_s1,
	input  logic [PARAM_FRAC_BITS:0]                  b_s1,
	output logic [bbp_pkg::NUM_W-1:0][PARAM_FRAC_BITS:0] w_s3
);
	import bbp_pkg::*;

	localparam int P = PARAM_FRAC_BITS;
	localparam logic [2*P+3:0] HALF = (2*P+4)'(1) << (P - 1);

	logic [2*P+1:0] aa_m, bb_m, ab_m;
	logic [2*P+1:0] aa_r, bb_r, ab_r;
	logic [P:0]     a_s2, b_s2, aa_s2, bb_s2, ab_s2;
	logic [P+2:0]   ab3;
	logic [2*P+3:0] w0_m, w1_m, w2_m, w3_m;
	logic [2*P+3:0] w0_r, w1_r, w2_r, w3_r;

	// Square terms, rounded half up
	assign aa_m = a_s1 * a_s1;
	assign bb_m = b_s1 * b_s1;
	assign ab_m = a_s1 * b_s1;
	assign aa_r = aa_m + HALF[2*P+1:0];
	assign bb_r = bb_m + HALF[2*P+1:0];
	assign ab_r = ab_m + HALF[2*P+1:0];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			aa_s2 <= aa_r[2*P:P];
			bb_s2 <= bb_r[2*P:P];
			ab_s2 <= ab_r[2*P:P];
		end
	end

	// Cubic terms; the factor three is a shift and add
	assign ab3  = {1'b0, ab_s2, 1'b0} + {2'b00, ab_s2};
	assign w0_m = bb_s2 * b_s2;
	assign w1_m = ab3 * b_s2;
	assign w2_m = ab3 * a_s2;
	assign w3_m = aa_s2 * a_s2;
	assign w0_r = w0_m + HALF;
	assign w1_r = w1_m + HALF;
	assign w2_r = w2_m + HALF;
	assign w3_r = w3_m + HALF;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			w_s3[0] <= w0_r[2*P:P];
			w_s3[1] <= w1_r[2*P:P];
			w_s3[2] <= w2_r[2*P:P];
			w_s3[3] <= w3_r[2*P:P];
		end
	end

endmodule

[design/bbp_blend.sv]
// Blend weights and control point products, stages 4 and 5, with the point store.
// Depends on bbp_pkg; the store is written in order with the words in the pipe.
module bbp_blend #(
	parameter int PARAM_FRAC_BITS = bbp_pkg::PFB_DEFAULT,
	parameter int PRW             = bbp_pkg::COORD_W + PARAM_FRAC_BITS + 2
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  bbp_pkg::stage_en_t                           en,
	input  logic [bbp_pkg::NUM_W-1:0][PARAM_FRAC_BITS:0] wu_s3,
	input  logic [bbp_pkg::NUM_W-1:0][PARAM_FRAC_BITS:0] wv_s3,
	input  bbp_pkg::cp_wr_t                              wr,
	output logic signed [PRW-1:0]                        prod_s5 [bbp_pkg::NUM_C][bbp_pkg::NUM_PTS]
);
	import bbp_pkg::*;

	localparam int P = PARAM_FRAC_BITS;
	localparam logic [2*P+1:0] HALF = (2*P+2)'(1) << (P - 1);

	point_t         cp_q     [NUM_PTS];
	logic [P:0]     blend_s4 [NUM_PTS];
	logic [2*P+1:0] bl_r     [NUM_PTS];

	// Hold the control grid; a load word writes one entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PTS; k++) cp_q[k] <= '0;
		end else if (wr.en) begin
			cp_q[wr.idx] <= wr.pt;
		end
	end

	// One blend weight and three products per control point
	for (genvar k = 0; k < NUM_PTS; k++) begin : g_pt
		logic [2*P+1:0] bl_m;

		assign bl_m    = wu_s3[k / GRID] * wv_s3[k % GRID];
		assign bl_r[k] = bl_m + HALF;

		always_ff @(posedge clk) begin
			if (en.s4) begin
				blend_s4[k] <= bl_r[k][2*P:P];
			end
		end

		for (genvar c = 0; c < NUM_C; c++) begin : g_c
			always_ff @(posedge clk) begin
				if (en.s5) begin
					prod_s5[c][k] <= $signed(cp_q[k][c]) * $signed({1'b0, blend_s4[k]});
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> cp_q[$past(wr.idx)] == $past(wr.pt))
		else $error("control point store lost a write");
`endif

endmodule

[design/bbp_accum.sv]
// Sum of the sixteen products per coordinate, rounding and saturation, stages 6 to 8.
// Depends on bbp_pkg; a two-level registered adder tree feeds the output register.
module bbp_accum #(
	parameter int PARAM_FRAC_BITS = bbp_pkg::PFB_DEFAULT,
	parameter int PRW             = bbp_pkg::COORD_W + PARAM_FRAC_BITS + 2
) (
	input  logic                         clk,
	input  bbp_pkg::stage_en_t           en,
	input  logic signed [PRW-1:0]        prod_s5 [bbp_pkg::NUM_C][bbp_pkg::NUM_PTS],
	output bbp_pkg::point_t              surf_s8
);
	import bbp_pkg::*;

	localparam int P     = PARAM_FRAC_BITS;
	localparam int PART_W = PRW + 2;
	localparam int ACC_W = PRW + 4;
	localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (P - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (COORD_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) << (COORD_W - 1));

	logic signed [PART_W-1:0] part_s6 [NUM_C][GRID];
	logic signed [ACC_W-1:0]  acc_s7  [NUM_C];
	logic signed [ACC_W-1:0]  rnd_c   [NUM_C];
	logic signed [ACC_W-1:0]  sh_c    [NUM_C];

	// Add the products of one control row
	always_ff @(posedge clk) begin
		if (en.s6) begin
			for (int c = 0; c < NUM_C; c++) begin
				for (int g = 0; g < GRID; g++) begin
					part_s6[c][g] <= prod_s5[c][GRID*g] + prod_s5[c][GRID*g+1]
						+ prod_s5[c][GRID*g+2] + prod_s5[c][GRID*g+3];
				end
			end
		end
	end

	// Add the row sums
	always_ff @(posedge clk) begin
		if (en.s7) begin
			for (int c = 0; c < NUM_C; c++) begin
				acc_s7[c] <= part_s6[c][0] + part_s6[c][1] + part_s6[c][2] + part_s6[c][3];
			end
		end
	end

	// Round half up with a floor shift
	always_comb begin
		for (int c = 0; c < NUM_C; c++) begin
			rnd_c[c] = acc_s7[c] + HALF;
			sh_c[c]  = rnd_c[c] >>> P;
		end
	end

	// Clip to the coordinate range
	always_ff @(posedge clk) begin
		if (en.s8) begin
			for (int c = 0; c < NUM_C; c++) begin
				if (sh_c[c] > SAT_HI) begin
					surf_s8[c] <= SAT_HI[COORD_W-1:0];
				end else if (sh_c[c] < SAT_LO) begin
					surf_s8[c] <= SAT_LO[COORD_W-1:0];
				end else begin
					surf_s8[c] <= sh_c[c][COORD_W-1:0];
				end
			end
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bicubic_bezier_patch_eval: random stalls on both channels.
// Depends on bbp_pkg and the bbp_in_if / bbp_out_if channel interfaces.
module testbench;
	import bbp_pkg::*;

	localparam int              PFB          = 16;
	localparam logic [PFB:0]    PARAM_ONE    = 17'h10000;
	localparam longint unsigned ROUND_HALF   = 64'd1 << (PFB - 1);
	localparam int              BERN_MID     = 3;
	localparam int              PIPE_DEPTH   = 8;
	localparam int              DRAIN_CYCLES = 2 * PIPE_DEPTH;
	localparam int              IDLE_LIMIT   = 2000;
	localparam int              N_RANDOM     = 400;
	localparam int              HOLD_AT      = 120;
	localparam int              HOLD_CYCLES  = 300;

	typedef struct {
		logic                      mode;
		logic [GRID_W-1:0]         row;
		logic [GRID_W-1:0]         col;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [PFB:0]              u;
		logic [PFB:0]              v;
	} word_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} coord_t;

	logic clk = 1'b0;
	logic arst_n;

	bbp_in_if #(.FRAC_BITS(PFB)) item_ch ();
	bbp_out_if result_ch ();

	bicubic_bezier_patch_eval #(.PARAM_FRAC_BITS(PFB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Control grid mirror, pending words and expected surface points
	coord_t ctrl_grid [NUM_PTS];
	word_t  word_q [$];
	coord_t surface_q [$];
	word_t  cur_word;

	int words_total;
	int words_taken;
	int n_loads;
	int n_evals;
	int n_clamped;
	int n_points;
	int n_errors;
	bit hold_done;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint unsigned round_u(input longint unsigned val);
		return (val + ROUND_HALF) >> PFB;
	endfunction

	function automatic longint round_s(input longint val);
		return (val + longint'(ROUND_HALF)) >>> PFB;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(input longint val);
		if (val > 32767)
			return 16'sh7fff;
		if (val < -32768)
			return 16'sh8000;
		return val[COORD_W-1:0];
	endfunction

	// Cubic Bernstein weights of one parameter, clamped to one
	function automatic void bernstein(input logic [PFB:0] t, output longint unsigned w [GRID]);
		longint unsigned a, b, aa, bb, ab;
		a = 64'((t > PARAM_ONE) ? PARAM_ONE : t);
		b = 64'(PARAM_ONE) - a;
		aa = round_u(a * a);
		bb = round_u(b * b);
		ab = round_u(a * b);
		w[0] = round_u(bb * b);
		w[1] = round_u(BERN_MID * ab * b);
		w[2] = round_u(BERN_MID * ab * a);
		w[3] = round_u(aa * a);
	endfunction

	// Blend all sixteen control points at (u, v)
	function automatic coord_t eval_surface(input logic [PFB:0] u, input logic [PFB:0] v);
		longint unsigned wu [GRID];
		longint unsigned wv [GRID];
		longint          acc_x, acc_y, acc_z, blend;
		coord_t          pt;
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		bernstein(u, wu);
		bernstein(v, wv);
		for (int i = 0; i < GRID; i++) begin
			for (int j = 0; j < GRID; j++) begin
				blend = longint'(round_u(wu[i] * wv[j]));
				acc_x += longint'(ctrl_grid[i*GRID+j].x) * blend;
				acc_y += longint'(ctrl_grid[i*GRID+j].y) * blend;
				acc_z += longint'(ctrl_grid[i*GRID+j].z) * blend;
			end
		end
		pt.x = sat_coord(round_s(acc_x));
		pt.y = sat_coord(round_s(acc_y));
		pt.z = sat_coord(round_s(acc_z));
		return pt;
	endfunction

	// Update the grid mirror or queue the expected point for one accepted word
	function automatic void take_word(input word_t w);
		if (w.mode == MODE_LOAD) begin
			ctrl_grid[{w.row, w.col}] = '{x: w.x, y: w.y, z: w.z};
			n_loads++;
		end else begin
			surface_q.push_back(eval_surface(w.u, w.v));
			if (w.u > PARAM_ONE || w.v > PARAM_ONE)
				n_clamped++;
			n_evals++;
		end
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 16'sh7fff;
		if (r < 16)
			return 16'sh8000;
		if (r < 20)
			return '0;
		return COORD_W'($urandom);
	endfunction

	function automatic logic [PFB:0] rand_param();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return (PFB+1)'($urandom_range(0, PARAM_ONE));
		if (r < 72)
			return '0;
		if (r < 79)
			return PARAM_ONE;
		if (r < 84)
			return PARAM_ONE - 1'b1;
		return (PFB+1)'($urandom_range(0, 2 * PARAM_ONE - 1));
	endfunction

	function automatic word_t make_load(input int row, input int col,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic signed [COORD_W-1:0] z);
		word_t w;
		w.mode = MODE_LOAD;
		w.row  = GRID_W'(row);
		w.col  = GRID_W'(col);
		w.x    = x;
		w.y    = y;
		w.z    = z;
		w.u    = (PFB+1)'($urandom);
		w.v    = (PFB+1)'($urandom);
		return w;
	endfunction

	function automatic word_t make_eval(input logic [PFB:0] u, input logic [PFB:0] v);
		word_t w;
		w.mode = MODE_EVAL;
		w.row  = GRID_W'($urandom);
		w.col  = GRID_W'($urandom);
		w.x    = COORD_W'($urandom);
		w.y    = COORD_W'($urandom);
		w.z    = COORD_W'($urandom);
		w.u    = u;
		w.v    = v;
		return w;
	endfunction

	// Sender: present pending words, hold on stall, insert random gaps
	int send_gap;
	bit send_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			send_gap = 0;
			send_calm = 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				take_word(cur_word);
				words_taken++;
			end
			if ($urandom_range(0, 63) == 0)
				send_calm = !send_calm;
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap > 0) begin
					item_ch.valid <= 1'b0;
					send_gap--;
				end else if (word_q.size() != 0) begin
					cur_word = word_q.pop_front();
					item_ch.valid     <= 1'b1;
					item_ch.mode      <= cur_word.mode;
					item_ch.point_row <= cur_word.row;
					item_ch.point_col <= cur_word.col;
					item_ch.coord_x   <= cur_word.x;
					item_ch.coord_y   <= cur_word.y;
					item_ch.coord_z   <= cur_word.z;
					item_ch.u_param   <= cur_word.u;
					item_ch.v_param   <= cur_word.v;
					send_gap = pick_gap(send_calm);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to back up the pipe
	int recv_stall;
	int recv_count;
	bit recv_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_stall = 0;
			recv_count = 0;
			recv_calm = 1'b0;
			hold_done = 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				recv_count++;
			if ($urandom_range(0, 63) == 0)
				recv_calm = !recv_calm;
			if (!hold_done && recv_count >= HOLD_AT) begin
				hold_done = 1'b1;
				recv_stall = HOLD_CYCLES;
			end
			if (recv_stall > 0) begin
				result_ch.ready <= 1'b0;
				recv_stall--;
			end else begin
				result_ch.ready <= 1'b1;
				recv_stall = pick_gap(recv_calm);
			end
		end
	end

	// Monitor: check each surface point against the oldest expectation
	always @(posedge clk) begin
		coord_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (surface_q.size() == 0) begin
				$display("%0t: unexpected surface point x=%0d y=%0d z=%0d", $time,
					result_ch.surf_x, result_ch.surf_y, result_ch.surf_z);
				n_errors++;
			end else begin
				want = surface_q.pop_front();
				n_points++;
				if (result_ch.surf_x !== want.x) begin
					$display("%0t: surf_x expected %0d got %0d", $time, want.x,
						result_ch.surf_x);
					n_errors++;
				end
				if (result_ch.surf_y !== want.y) begin
					$display("%0t: surf_y expected %0d got %0d", $time, want.y,
						result_ch.surf_y);
					n_errors++;
				end
				if (result_ch.surf_z !== want.z) begin
					$display("%0t: surf_z expected %0d got %0d", $time, want.z,
						result_ch.surf_z);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("bicubic_bezier_patch_eval regression: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [PFB:0] u_pick [6];
		logic [PFB:0] v_pick [6];
		int r;

		// Hold inputs at known levels and assert reset
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.mode        = MODE_LOAD;
		item_ch.point_row   = '0;
		item_ch.point_col   = '0;
		item_ch.coord_x     = '0;
		item_ch.coord_y     = '0;
		item_ch.coord_z     = '0;
		item_ch.u_param     = '0;
		item_ch.v_param     = '0;
		result_ch.ready     = 1'b0;
		foreach (ctrl_grid[k])
			ctrl_grid[k] = '{x: '0, y: '0, z: '0};
		words_taken = 0;
		n_loads     = 0;
		n_evals     = 0;
		n_clamped   = 0;
		n_points    = 0;
		n_errors    = 0;

		// Directed: evaluate the cleared grid, then a grid at the coordinate extremes
		word_q.push_back(make_eval(PARAM_ONE >> 1, PARAM_ONE >> 1));
		for (int k = 0; k < NUM_PTS; k++)
			word_q.push_back(make_load(k / GRID, k % GRID, 16'sh7fff, 16'sh8000,
				(k % 2) ? 16'sh7fff : 16'sh8000));
		u_pick = '{17'd0, PARAM_ONE, 17'h1ffff, PARAM_ONE >> 1, 17'd0, 17'd21845};
		v_pick = '{17'd0, PARAM_ONE, 17'd0, PARAM_ONE >> 1, 17'h1ffff, 17'd43690};
		for (int k = 0; k < 6; k++)
			word_q.push_back(make_eval(u_pick[k], v_pick[k]));

		// Random: mostly evaluates, with loads reshaping the patch along the way
		for (int k = 0; k < N_RANDOM; k++) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				word_q.push_back(make_load($urandom_range(0, GRID - 1),
					$urandom_range(0, GRID - 1), rand_coord(), rand_coord(), rand_coord()));
			else
				word_q.push_back(make_eval(rand_param(), rand_param()));
		end
		words_total = word_q.size();

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Drain, then let any stray output show up
		while (words_taken != words_total || surface_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d loads and %0d evaluates (%0d with a clamped parameter).",
			n_loads, n_evals, n_clamped);
		$display("Checked %0d surface points, %0d field mismatches, long output hold-off %0s.",
			n_points, n_errors, hold_done ? "done" : "not reached");
		if (n_errors == 0 && surface_q.size() == 0)
			$display("bicubic_bezier_patch_eval regression: pass");
		else
			$display("bicubic_bezier_patch_eval regression: fail");
		$finish;
	end

endmodule

[bicubic_bezier_patch_eval.f]
design/bbp_pkg.sv
design/bbp_if.sv
design/bbp_weight.sv
design/bbp_blend.sv
design/bbp_accum.sv
design/bicubic_bezier_patch_eval.sv
tb/testbench.sv
